// File: design/rbs_pkg.sv
// Shared constants, widths and types of the record bubble sorter.
// Used by the channel interfaces, the key store and the top level.
package rbs_pkg;

    localparam int MAX_RECORDS   = 64;
    localparam int MAX_KEY_WORDS = 9;
    localparam int REC_W         = $clog2(MAX_RECORDS);
    localparam int CNT_W         = REC_W + 1;
    localparam int WIDX_W        = 4;
    localparam int KEY_W         = 64;
    localparam int KEY_DEPTH     = MAX_RECORDS * MAX_KEY_WORDS;
    localparam int KEY_ADDR_W    = $clog2(KEY_DEPTH);
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    localparam logic [KIND_W-1:0]    KIND_DOUBLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_KIND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORDS = 2'd1;

    typedef struct packed {
        logic                  wr_en;
        logic [KEY_ADDR_W-1:0] wr_addr;
        logic                  rd_en;
        logic [KEY_ADDR_W-1:0] rd_addr_a;
        logic [KEY_ADDR_W-1:0] rd_addr_b;
    } key_ctl_t;

    typedef struct packed {
        logic differ;
        logic greater;
    } cmp_t;

    function automatic logic [KEY_ADDR_W-1:0] key_addr(
        input logic [REC_W-1:0]  rec,
        input logic [WIDX_W-1:0] widx
    );
        return KEY_ADDR_W'(rec) * KEY_ADDR_W'(MAX_KEY_WORDS) + KEY_ADDR_W'(widx);
    endfunction

endpackage

// File: design/rbs_ifs.sv
// Valid/ready channel interfaces: key word input, sorted result output and
// configuration write. Depends on rbs_pkg.
interface rbs_item_if;
    logic                        valid;
    logic                        ready;
    logic [rbs_pkg::REC_W-1:0]   record_index;
    logic [rbs_pkg::WIDX_W-1:0]  word_index;
    logic [rbs_pkg::KEY_W-1:0]   key_word;
    logic                        last_item;

    modport source (output valid, record_index, word_index, key_word, last_item,
                    input ready);
    modport sink   (input valid, record_index, word_index, key_word, last_item,
                    output ready);
endinterface

interface rbs_result_if;
    logic                      valid;
    logic                      ready;
    logic [rbs_pkg::REC_W-1:0] rank;
    logic [rbs_pkg::REC_W-1:0] sorted_index;
    logic                      last_result;

    modport source (output valid, rank, sorted_index, last_result, input ready);
    modport sink   (input valid, rank, sorted_index, last_result, output ready);
endinterface

interface rbs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rbs_pkg::CFG_IDX_W-1:0]  index;
    logic [rbs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/rbs_key_cmp.sv
// Key word memory with two registered read ports and the word comparator.
// Depends on rbs_pkg.
module rbs_key_cmp (
    input  logic                           clk,
    input  rbs_pkg::key_ctl_t              ctl,
    input  logic [rbs_pkg::KEY_W-1:0]      wr_data,
    input  logic [rbs_pkg::KIND_W-1:0]     kind,
    output rbs_pkg::cmp_t                  status
);

    logic [rbs_pkg::KEY_W-1:0] key_mem [rbs_pkg::KEY_DEPTH];
    logic [rbs_pkg::KEY_W-1:0] word_a_reg;
    logic [rbs_pkg::KEY_W-1:0] word_b_reg;
    logic [rbs_pkg::KEY_W-1:0] ord_a;
    logic [rbs_pkg::KEY_W-1:0] ord_b;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            key_mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            word_a_reg <= key_mem[ctl.rd_addr_a];
            word_b_reg <= key_mem[ctl.rd_addr_b];
        end
    end

    // Map doubles onto unsigned order: negative words invert, others flip sign.
    always_comb
    begin
        ord_a = word_a_reg;
        ord_b = word_b_reg;
        if (kind == rbs_pkg::KIND_DOUBLE)
        begin
            ord_a = word_a_reg[rbs_pkg::KEY_W-1] ? ~word_a_reg
                  : {1'b1, word_a_reg[rbs_pkg::KEY_W-2:0]};
            ord_b = word_b_reg[rbs_pkg::KEY_W-1] ? ~word_b_reg
                  : {1'b1, word_b_reg[rbs_pkg::KEY_W-2:0]};
        end
        status.differ  = (ord_a != ord_b);
        status.greater = (ord_a > ord_b);
    end

endmodule

// File: design/record_bubble_sorter_unit.sv
// Record bubble sorter top level: load sequencer, order memory, sort and emit.
// Depends on rbs_pkg, rbs_ifs and rbs_key_cmp.
//
//  channel | dir | payload                                      | transfer
//  item    | in  | record_index, word_index, key_word, last_item | valid & ready
//  result  | out | rank, sorted_index, last_result              | valid & ready
//  cfg     | in  | index, data (0 key_kind, 1 key_words)         | valid & ready
//
// Load: one key word per cycle. After last_item the input stalls while the sort
// runs: it seeds the order memory, then in each pass compares neighbors key word
// by key word until they differ; emit then reads each result through the
// single read port of the order memory.
// Reset clears control and kind, sets key words to 1; key memory is not reset.
// A stalled result holds in the output register; input is taken again once the
// final result is registered.
module record_bubble_sorter_unit (
    input  logic       clk,
    input  logic       rst_n,
    rbs_item_if.sink   item,
    rbs_result_if.source result,
    rbs_cfg_if.sink    cfg
);

    typedef enum logic [10:0] {
        ST_LOAD = 11'b000_0000_0001,
        ST_INIT = 11'b000_0000_0010,
        ST_PASS = 11'b000_0000_0100,
        ST_NEXT = 11'b000_0000_1000,
        ST_GETN = 11'b000_0001_0000,
        ST_KRD  = 11'b000_0010_0000,
        ST_KCMP = 11'b000_0100_0000,
        ST_DEC  = 11'b000_1000_0000,
        ST_TAIL = 11'b001_0000_0000,
        ST_ERD  = 11'b010_0000_0000,
        ST_EOUT = 11'b100_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [rbs_pkg::KIND_W-1:0]      kind_reg;
    logic [rbs_pkg::WIDX_W-1:0]      words_reg;
    logic [rbs_pkg::WIDX_W-1:0]      kw_eff;
    logic [rbs_pkg::CNT_W-1:0]       total_reg, total_next;
    logic [rbs_pkg::REC_W-1:0]       idx_reg, idx_next;
    logic [rbs_pkg::REC_W-1:0]       pass_reg, pass_next;
    logic [rbs_pkg::WIDX_W-1:0]      k_reg, k_next;
    logic [rbs_pkg::REC_W-1:0]       carry_reg, carry_next;
    logic [rbs_pkg::REC_W-1:0]       nxt_reg, nxt_next;
    logic                            first_reg, first_next;
    logic                            gt_reg, gt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rbs_pkg::REC_W-1:0]       out_rank_reg, out_rank_next;
    logic [rbs_pkg::REC_W-1:0]       out_index_reg, out_index_next;
    logic                            out_last_reg, out_last_next;

    logic [rbs_pkg::REC_W-1:0]       ord_mem [rbs_pkg::MAX_RECORDS];
    logic                            ord_we;
    logic [rbs_pkg::REC_W-1:0]       ord_wa;
    logic [rbs_pkg::REC_W-1:0]       ord_wd;
    logic                            ord_re;
    logic [rbs_pkg::REC_W-1:0]       ord_ra;
    logic [rbs_pkg::REC_W-1:0]       ord_rd_reg;

    rbs_pkg::key_ctl_t               key_ctl;
    rbs_pkg::cmp_t                   cmp;
    logic                            item_xfer;
    logic                            out_xfer;
    logic [rbs_pkg::CNT_W-1:0]       idx_inc;

    assign item.ready     = (state_reg == ST_LOAD);
    assign item_xfer      = item.valid && item.ready;
    assign out_xfer       = out_valid_reg && result.ready;
    assign cfg.ready      = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.rank         = out_rank_reg;
    assign result.sorted_index = out_index_reg;
    assign result.last_result  = out_last_reg;
    assign idx_inc        = rbs_pkg::CNT_W'(idx_reg) + rbs_pkg::CNT_W'(1);

    always_comb
    begin
        if (words_reg == '0)
        begin
            kw_eff = rbs_pkg::WIDX_W'(1);
        end
        else if (words_reg > rbs_pkg::WIDX_W'(rbs_pkg::MAX_KEY_WORDS))
        begin
            kw_eff = rbs_pkg::WIDX_W'(rbs_pkg::MAX_KEY_WORDS);
        end
        else
        begin
            kw_eff = words_reg;
        end
    end

    rbs_key_cmp u_key_cmp (
        .clk     (clk),
        .ctl     (key_ctl),
        .wr_data (item.key_word),
        .kind    (kind_reg),
        .status  (cmp)
    );

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_wa] <= ord_wd;
        end
        if (ord_re)
        begin
            ord_rd_reg <= ord_mem[ord_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= '0;
            words_reg <= rbs_pkg::WIDX_W'(1);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rbs_pkg::CFG_KEY_KIND)
            begin
                kind_reg <= cfg.data[rbs_pkg::KIND_W-1:0];
            end
            else if (cfg.index == rbs_pkg::CFG_KEY_WORDS)
            begin
                words_reg <= cfg.data[rbs_pkg::WIDX_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        nxt_next       = nxt_reg;
        first_next     = first_reg;
        gt_next        = gt_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        out_rank_next  = out_rank_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        ord_we         = 1'b0;
        ord_wa         = idx_reg;
        ord_wd         = idx_reg;
        ord_re         = 1'b0;
        ord_ra         = idx_reg;
        key_ctl.wr_en     = 1'b0;
        key_ctl.wr_addr   = rbs_pkg::key_addr(item.record_index, item.word_index);
        key_ctl.rd_en     = 1'b0;
        key_ctl.rd_addr_a = rbs_pkg::key_addr(carry_reg, k_reg);
        key_ctl.rd_addr_b = rbs_pkg::key_addr(nxt_reg, k_reg);

        case (state_reg)
            ST_LOAD:
            begin
                if (item_xfer)
                begin
                    key_ctl.wr_en = (item.word_index
                                     < rbs_pkg::WIDX_W'(rbs_pkg::MAX_KEY_WORDS));
                    if (item.last_item)
                    begin
                        total_next = rbs_pkg::CNT_W'(item.record_index)
                                   + rbs_pkg::CNT_W'(1);
                        idx_next   = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                ord_we = 1'b1;
                if (idx_inc == total_reg)
                begin
                    idx_next  = '0;
                    pass_next = idx_reg;
                    state_next = (idx_reg == '0) ? ST_ERD : ST_PASS;
                end
                else
                begin
                    idx_next = idx_inc[rbs_pkg::REC_W-1:0];
                end
            end
            ST_PASS:
            begin
                ord_re     = 1'b1;
                ord_ra     = '0;
                idx_next   = '0;
                first_next = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (first_reg)
                begin
                    carry_next = ord_rd_reg;
                end
                first_next = 1'b0;
                ord_re     = 1'b1;
                ord_ra     = idx_inc[rbs_pkg::REC_W-1:0];
                state_next = ST_GETN;
            end
            ST_GETN:
            begin
                nxt_next   = ord_rd_reg;
                k_next     = '0;
                state_next = ST_KRD;
            end
            ST_KRD:
            begin
                key_ctl.rd_en = 1'b1;
                state_next    = ST_KCMP;
            end
            ST_KCMP:
            begin
                if (cmp.differ)
                begin
                    gt_next    = cmp.greater;
                    state_next = ST_DEC;
                end
                else if (k_reg + rbs_pkg::WIDX_W'(1) == kw_eff)
                begin
                    gt_next    = 1'b0;
                    state_next = ST_DEC;
                end
                else
                begin
                    k_next     = k_reg + rbs_pkg::WIDX_W'(1);
                    state_next = ST_KRD;
                end
            end
            ST_DEC:
            begin
                // Keep the larger key moving right; drop the smaller one in place.
                ord_we = 1'b1;
                if (gt_reg)
                begin
                    ord_wd = nxt_reg;
                end
                else
                begin
                    ord_wd     = carry_reg;
                    carry_next = nxt_reg;
                end
                if (idx_inc == rbs_pkg::CNT_W'(pass_reg))
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next   = idx_inc[rbs_pkg::REC_W-1:0];
                    state_next = ST_NEXT;
                end
            end
            ST_TAIL:
            begin
                ord_we    = 1'b1;
                ord_wa    = pass_reg;
                ord_wd    = carry_reg;
                pass_next = pass_reg - rbs_pkg::REC_W'(1);
                idx_next  = '0;
                state_next = (pass_reg == rbs_pkg::REC_W'(1)) ? ST_ERD : ST_PASS;
            end
            ST_ERD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    ord_re     = 1'b1;
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT:
            begin
                out_valid_next = 1'b1;
                out_rank_next  = idx_reg;
                out_index_next = ord_rd_reg;
                out_last_next  = (idx_inc == total_reg);
                if (idx_inc == total_reg)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next   = idx_inc[rbs_pkg::REC_W-1:0];
                    state_next = ST_ERD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            total_reg     <= '0;
            idx_reg       <= '0;
            pass_reg      <= '0;
            k_reg         <= '0;
            first_reg     <= 1'b0;
            gt_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            k_reg         <= k_next;
            first_reg     <= first_next;
            gt_reg        <= gt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg     <= carry_next;
        nxt_reg       <= nxt_next;
        out_rank_reg  <= out_rank_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

endmodule
